FILE: rtl/core/kvh_pkg.sv
// Shared types and constants for the key-value hash table.
// Used by the front end, the back end, the top level and the checker.
package kvh_pkg;

  localparam int CAPACITY    = 256;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] ACT_PUT    = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [63:0]      value_out;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } out_t;

  // An accepted item after decoding of its action.
  typedef struct packed {
    logic        is_put;
    logic        is_get;
    logic        is_rem;
    logic [63:0] key;
    logic [63:0] value;
  } job_t;

endpackage

FILE: rtl/core/kvh_front.sv
// Front end of the key-value hash table: accepts items, decodes the action
// and holds them in a short queue for the back end. Depends on kvh_pkg.
module kvh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kvh_pkg::in_t  cmd,
  output logic          q_valid,
  output kvh_pkg::job_t q_data,
  input  logic          pop
);

  kvh_pkg::job_t                 queue [kvh_pkg::QUEUE_DEPTH];
  logic [kvh_pkg::QPTR_W-1:0]    wr_ptr;
  logic [kvh_pkg::QPTR_W-1:0]    rd_ptr;
  logic [kvh_pkg::QCNT_W-1:0]    fill;
  kvh_pkg::job_t                 job_in;
  logic                          push;
  logic                          take;

  // Decode the action into one flag per operation; the unused code sets none.
  always_comb begin
    job_in.is_put = (cmd.action == kvh_pkg::ACT_PUT);
    job_in.is_get = (cmd.action == kvh_pkg::ACT_GET);
    job_in.is_rem = (cmd.action == kvh_pkg::ACT_REMOVE);
    job_in.key    = cmd.key;
    job_in.value  = cmd.value;
  end

  assign busy    = (fill == kvh_pkg::QCNT_W'(kvh_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign take    = pop && q_valid;
  assign q_data  = queue[rd_ptr];

  // Queue storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= job_in;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !take) begin
        fill <= fill + 1'b1;
      end else if (take && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/kvh_back.sv
// Back end of the key-value hash table: entry memories, the sequential key
// search and the update of the packed entry list. Depends on kvh_pkg.
module kvh_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  kvh_pkg::job_t q_data,
  output logic          pop,
  output logic          done,
  output kvh_pkg::out_t result
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_MOVE    = 2'd2;
  localparam logic [1:0] S_MOVE_WR = 2'd3;

  // Entries are kept packed in slots 0 .. count-1.
  logic [63:0]               key_mem [kvh_pkg::CAPACITY];
  logic [63:0]               val_mem [kvh_pkg::CAPACITY];
  logic [63:0]               key_q;
  logic [63:0]               val_q;
  logic [1:0]                state;
  kvh_pkg::job_t             job;
  logic [kvh_pkg::IDX_W-1:0] idx;
  logic [kvh_pkg::CNT_W-1:0] count;
  logic [kvh_pkg::CNT_W-1:0] cnt_m1;
  logic [kvh_pkg::CNT_W-1:0] cnt_p1;
  logic [kvh_pkg::IDX_W-1:0] last;
  logic [kvh_pkg::IDX_W-1:0] rd_addr;
  logic [63:0]               vout;
  logic                      match;
  logic                      at_end;
  logic                      we;
  logic [kvh_pkg::IDX_W-1:0] wa;
  logic [63:0]               wk;
  logic [63:0]               wv;

  assign cnt_m1 = count - 1'b1;
  assign cnt_p1 = count + 1'b1;
  assign last   = cnt_m1[kvh_pkg::IDX_W-1:0];
  assign match  = (count != '0) && (key_q == job.key);
  assign at_end = (count == '0) || (idx == last);
  assign pop    = (state == S_IDLE) && q_valid;

  // Read address: the next slot while scanning, the last slot when compacting.
  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = idx + 1'b1;
      S_MOVE:  rd_addr = last;
      default: rd_addr = '0;
    endcase
  end

  // Write port: overwrite on put hit, append on put miss, fill a removed hole.
  always_comb begin
    we = 1'b0;
    wa = idx;
    wk = job.key;
    wv = job.value;
    if (state == S_SCAN && job.is_put) begin
      if (match) begin
        we = 1'b1;
      end else if (at_end && count < kvh_pkg::CAP_CNT) begin
        we = 1'b1;
        wa = count[kvh_pkg::IDX_W-1:0];
      end
    end else if (state == S_MOVE_WR) begin
      we = 1'b1;
      wk = key_q;
      wv = val_q;
    end
  end

  // Entry memories with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa] <= wk;
      val_mem[wa] <= wv;
    end
    key_q <= key_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  // Job and removed-value holding registers carry no reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_data;
    end
    if (state == S_SCAN) begin
      vout <= val_q;
    end
  end

  // Sequencer: scan one slot a cycle, then commit and report the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            result.status    <= kvh_pkg::ST_OK;
            result.found     <= 1'b1;
            result.value_out <= (job.is_get || job.is_rem) ? val_q : 64'd0;
            if (job.is_rem && idx != last) begin
              state <= S_MOVE;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
              if (job.is_rem) begin
                count              <= cnt_m1;
                result.entry_count <= cnt_m1;
                result.is_empty    <= (cnt_m1 == '0);
              end else begin
                result.entry_count <= count;
                result.is_empty    <= (count == '0);
              end
            end
          end else if (at_end) begin
            done             <= 1'b1;
            state            <= S_IDLE;
            result.found     <= 1'b0;
            result.value_out <= 64'd0;
            if (job.is_put && count < kvh_pkg::CAP_CNT) begin
              count              <= cnt_p1;
              result.status      <= kvh_pkg::ST_OK;
              result.entry_count <= cnt_p1;
              result.is_empty    <= 1'b0;
            end else begin
              if (job.is_put) begin
                result.status <= kvh_pkg::ST_FULL;
              end else if (job.is_get || job.is_rem) begin
                result.status <= kvh_pkg::ST_NOT_FOUND;
              end else begin
                result.status <= kvh_pkg::ST_OK;
              end
              result.entry_count <= count;
              result.is_empty    <= (count == '0);
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MOVE: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          done               <= 1'b1;
          state              <= S_IDLE;
          count              <= cnt_m1;
          result.status      <= kvh_pkg::ST_OK;
          result.found       <= 1'b1;
          result.value_out   <= vout;
          result.entry_count <= cnt_m1;
          result.is_empty    <= (cnt_m1 == '0);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/key_value_hash_table.sv
// Top level of the key-value hash table: front end, queue and back end.
// Depends on kvh_pkg, kvh_front and kvh_back.
//
// Usage: present an item on cmd (action, key, value) with start high; it
// is taken at a rising edge where start is high and busy is low. busy rises
// only when the two-beat queue between front and back end is full.
// Each item gives one result beat on result, marked by done for exactly one
// cycle; the receiver must take it then, as it cannot stall the block.
// Entries are stored packed in slots 0 .. entry_count-1 of two 256-deep
// memories (key and value), read one slot per cycle through a registered
// port. An item waits at the queue head until the back end is idle, then
// scans the slots in order up to a hit, or through every entry on a miss.
// A remove that leaves a hole then passes through S_MOVE and S_MOVE_WR to
// move the last entry into it. Items are worked one at a time: the back
// end takes no new item from the queue until it has reported the last.
// Reset empties the table (entry count zero) and the queue; no clearing
// pass is needed.
module key_value_hash_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kvh_pkg::in_t  cmd,
  output logic          done,
  output kvh_pkg::out_t result
);

  logic          q_valid;
  logic          pop;
  kvh_pkg::job_t q_data;

  kvh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop)
  );

  kvh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: rtl/core/kvh_checker.sv
// Port-level checks for the key-value hash table, bound to the top level.
// Depends on kvh_pkg.
module kvh_checker (
  input logic          clk,
  input logic          rst,
  input logic          done,
  input kvh_pkg::out_t result
);

  // No result beat follows a reset cycle.
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat straight after reset");

  // The empty flag agrees with the count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  // A full status only comes from a full table.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == kvh_pkg::ST_FULL) |-> (result.entry_count == kvh_pkg::CAP_CNT))
    else $error("full status below capacity");

  // A present key is never reported as not found.
  a_found: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.status == kvh_pkg::ST_OK))
    else $error("found key with failing status");

endmodule

bind key_value_hash_table kvh_checker u_kvh_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);
